// File: sv/breakpoint_bilinear_map_lookup_assert.svh
// Assertion macros for the breakpoint bilinear map lookup.
`ifndef BREAKPOINT_BILINEAR_MAP_LOOKUP_ASSERT_SVH
`define BREAKPOINT_BILINEAR_MAP_LOOKUP_ASSERT_SVH

`ifndef SYNTHESIS
`define BBML_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbml: implication check failed");
`define BBML_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbml: next-cycle check failed");
`else
`define BBML_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BBML_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/bbml_pkg.sv
// Shared constants and types for the breakpoint bilinear map lookup.
package bbml_pkg;

   localparam int MAX_POINTS_DEFAULT = 32;

   localparam int CELL_W     = 9;
   localparam int DIFF_W     = 10;
   localparam int BYTE_W     = 8;
   localparam int PROD_W     = 19;
   localparam int PROD_MAG_W = 17;
   localparam int INDEX_W    = 5;
   localparam int EXT_W      = 7;
   localparam int COORD_W    = 16;

   localparam logic [1:0] CMD_LOOKUP  = 2'd0;
   localparam logic [1:0] CMD_WRITE_X = 2'd1;
   localparam logic [1:0] CMD_WRITE_Y = 2'd2;
   localparam logic [1:0] CMD_WRITE_M = 2'd3;

   localparam logic [1:0] CSR_LAST_COL = 2'd0;
   localparam logic [1:0] CSR_LAST_ROW = 2'd1;
   localparam logic [1:0] CSR_SIGNED   = 2'd2;
   localparam logic [1:0] CSR_DOUBLE   = 2'd3;

   localparam logic [INDEX_W-1:0] LAST_COL_RESET = 5'd15;
   localparam logic [INDEX_W-1:0] LAST_ROW_RESET = 5'd16;

   typedef struct packed {
      logic                     start;
      logic signed [CELL_W-1:0] v1;
      logic signed [CELL_W-1:0] v2;
      logic [BYTE_W-1:0]        dx;
      logic [BYTE_W-1:0]        span;
   } lerp_req_type;

endpackage

// File: sv/breakpoint_bilinear_map_lookup.sv
// Top level of the breakpoint bilinear map lookup: sequencer, tables, config.
//
//   channel   signals                      use
//   req       req_valid / req_ready        command: lookup or table write
//   rsp       rsp_valid / rsp_ready        interpolated result, one per lookup
//   csr       csr_we / csr_index           register write, no wait
//
// A table write leaves the sequencer idle. A lookup holds the sequencer while
// each breakpoint scan reads one entry at a time from its axis RAM, and up to three
// interpolations pass through the one shared divider.
// Reset is synchronous; tables are not cleared. A stalled rsp holds the
// sequencer only at the final result transfer.
module breakpoint_bilinear_map_lookup import bbml_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [INDEX_W-1:0]        req_row_index,
   input  logic [INDEX_W-1:0]        req_column_index,
   input  logic [BYTE_W-1:0]         req_write_value,
   input  logic signed [COORD_W-1:0] req_x_value,
   input  logic signed [COORD_W-1:0] req_y_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_interpolated,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [INDEX_W-1:0]        csr_wdata
);

   `include "breakpoint_bilinear_map_lookup_assert.svh"

   localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CELLS = MAX_POINTS * MAX_POINTS;
   localparam int MW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_X0   = 5'd1;
   localparam logic [4:0] S_X0W  = 5'd2;
   localparam logic [4:0] S_XL   = 5'd3;
   localparam logic [4:0] S_XLW  = 5'd4;
   localparam logic [4:0] S_XS   = 5'd5;
   localparam logic [4:0] S_XSW  = 5'd6;
   localparam logic [4:0] S_Y0   = 5'd7;
   localparam logic [4:0] S_Y0W  = 5'd8;
   localparam logic [4:0] S_YL   = 5'd9;
   localparam logic [4:0] S_YLW  = 5'd10;
   localparam logic [4:0] S_YS   = 5'd11;
   localparam logic [4:0] S_YSW  = 5'd12;
   localparam logic [4:0] S_C0   = 5'd13;
   localparam logic [4:0] S_C0W  = 5'd14;
   localparam logic [4:0] S_C1   = 5'd15;
   localparam logic [4:0] S_C1W  = 5'd16;
   localparam logic [4:0] S_CL   = 5'd17;
   localparam logic [4:0] S_CD   = 5'd18;
   localparam logic [4:0] S_FL   = 5'd19;
   localparam logic [4:0] S_OUT  = 5'd20;

   // config registers
   logic [INDEX_W-1:0] last_col_ff, last_row_ff;
   logic               signed_ff, double_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= LAST_COL_RESET;
         last_row_ff <= LAST_ROW_RESET;
         signed_ff   <= 1'b0;
         double_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LAST_COL: last_col_ff <= csr_wdata;
            CSR_LAST_ROW: last_row_ff <= csr_wdata;
            CSR_SIGNED:   signed_ff   <= csr_wdata[0];
            CSR_DOUBLE:   double_ff   <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   logic [AW-1:0] ubx, uby;
   assign ubx = (EXT_W'(last_col_ff) > EXT_W'(MAX_POINTS - 1)) ? AW'(MAX_POINTS - 1)
                                                              : AW'(last_col_ff);
   assign uby = (EXT_W'(last_row_ff) > EXT_W'(MAX_POINTS - 1)) ? AW'(MAX_POINTS - 1)
                                                              : AW'(last_row_ff);

   // sequencer registers
   logic [4:0]                state_ff, state_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [AW-1:0]             p_ff, p_in, q_ff, q_in;
   logic [AW-1:0]             r0_ff, r0_in, r1_ff, r1_in;
   logic [BYTE_W-1:0]         xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [BYTE_W-1:0]         ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic [BYTE_W-1:0]         prev_ff, prev_in;
   logic                      ypair_ff, ypair_in;
   logic                      col_sel_ff, col_sel_in;
   logic signed [CELL_W-1:0]  v1_ff, v1_in, zp_ff, zp_in, z_ff, z_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_data_ff, rsp_data_in;

   // tables
   logic                 accept;
   logic                 x_we, y_we, m_we;
   logic [AW-1:0]        x_raddr, y_raddr;
   logic [MW-1:0]        m_waddr, m_raddr;
   logic [AW-1:0]        m_row, m_col;
   logic [BYTE_W-1:0]    x_rdata, y_rdata, m_rdata;
   logic                 col_ok, row_ok;

   assign accept  = req_valid && req_ready;
   assign col_ok  = EXT_W'(req_column_index) < EXT_W'(MAX_POINTS);
   assign row_ok  = EXT_W'(req_row_index) < EXT_W'(MAX_POINTS);
   assign x_we    = accept && req_command == CMD_WRITE_X && col_ok;
   assign y_we    = accept && req_command == CMD_WRITE_Y && row_ok;
   assign m_we    = accept && req_command == CMD_WRITE_M && col_ok && row_ok;
   assign m_waddr = MW'(MW'(AW'(req_row_index)) * MW'(MAX_POINTS))
                    + MW'(AW'(req_column_index));

   assign x_raddr = (state_ff == S_X0) ? '0 : (state_ff == S_XL) ? ubx : idx_ff;
   assign y_raddr = (state_ff == S_Y0) ? '0 : (state_ff == S_YL) ? uby : idx_ff;
   assign m_row   = (state_ff == S_C0) ? r0_ff : r1_ff;
   assign m_col   = col_sel_ff ? q_ff : p_ff;
   assign m_raddr = MW'(MW'(m_row) * MW'(MAX_POINTS)) + MW'(m_col);

   bbml_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_POINTS)) u_x_ram (
      .clock(clock), .we(x_we), .waddr(AW'(req_column_index)), .wdata(req_write_value),
      .raddr(x_raddr), .rdata(x_rdata));

   bbml_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_POINTS)) u_y_ram (
      .clock(clock), .we(y_we), .waddr(AW'(req_row_index)), .wdata(req_write_value),
      .raddr(y_raddr), .rdata(y_rdata));

   bbml_ram #(.WIDTH(BYTE_W), .DEPTH(CELLS)) u_map_ram (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(req_write_value),
      .raddr(m_raddr), .rdata(m_rdata));

   // shared interpolation unit
   lerp_req_type             lerp_req;
   logic                     lerp_busy, lerp_done;
   logic signed [CELL_W-1:0] lerp_result;

   bbml_lerp u_lerp (
      .clock(clock), .reset(reset), .req(lerp_req),
      .busy(lerp_busy), .done(lerp_done), .result(lerp_result));

   logic signed [COORD_W:0]   x_ext, y_ext, xbp_ext, ybp_ext;
   logic signed [CELL_W-1:0]  cell_val;
   logic [COORD_W-1:0]        dy_full, dx_full;
   logic signed [COORD_W-1:0] z_ext;

   always_comb begin
      x_ext    = {x_ff[COORD_W-1], x_ff};
      y_ext    = {y_ff[COORD_W-1], y_ff};
      xbp_ext  = $signed({{(COORD_W + 1 - BYTE_W){1'b0}}, x_rdata});
      ybp_ext  = $signed({{(COORD_W + 1 - BYTE_W){1'b0}}, y_rdata});
      cell_val = $signed({signed_ff & m_rdata[BYTE_W-1], m_rdata});
      dy_full  = COORD_W'(y_ff) - COORD_W'(ylo_ff);
      dx_full  = COORD_W'(x_ff) - COORD_W'(xlo_ff);
      z_ext    = COORD_W'(z_ff);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      xlo_in       = xlo_ff;
      xhi_in       = xhi_ff;
      ylo_in       = ylo_ff;
      yhi_in       = yhi_ff;
      prev_in      = prev_ff;
      ypair_in     = ypair_ff;
      col_sel_in   = col_sel_ff;
      v1_in        = v1_ff;
      zp_in        = zp_ff;
      z_in         = z_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      lerp_req     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_command == CMD_LOOKUP) begin
               x_in       = req_x_value;
               y_in       = req_y_value;
               ypair_in   = 1'b0;
               col_sel_in = 1'b0;
               state_in   = S_X0;
            end
         end
         S_X0: state_in = S_X0W;
         S_X0W: begin
            prev_in = x_rdata;
            if (x_ext <= xbp_ext) begin
               p_in     = '0;
               q_in     = '0;
               state_in = S_Y0;
            end else begin
               state_in = S_XL;
            end
         end
         S_XL: state_in = S_XLW;
         S_XLW: begin
            if (x_ext >= xbp_ext) begin
               p_in     = ubx;
               q_in     = ubx;
               state_in = S_Y0;
            end else begin
               idx_in   = AW'(1);
               state_in = S_XS;
            end
         end
         S_XS: state_in = S_XSW;
         S_XSW: begin
            if (x_ext <= xbp_ext) begin
               p_in     = idx_ff - AW'(1);
               q_in     = idx_ff;
               xlo_in   = prev_ff;
               xhi_in   = x_rdata;
               state_in = S_Y0;
            end else begin
               prev_in  = x_rdata;
               idx_in   = idx_ff + AW'(1);
               state_in = S_XS;
            end
         end
         S_Y0: state_in = S_Y0W;
         S_Y0W: begin
            prev_in = y_rdata;
            if (y_ext < ybp_ext) begin
               r0_in    = '0;
               state_in = S_C0;
            end else begin
               state_in = S_YL;
            end
         end
         S_YL: state_in = S_YLW;
         S_YLW: begin
            if (y_ext >= ybp_ext) begin
               r0_in    = uby;
               state_in = S_C0;
            end else begin
               idx_in   = AW'(1);
               state_in = S_YS;
            end
         end
         S_YS: state_in = S_YSW;
         S_YSW: begin
            if (y_ext < ybp_ext) begin
               r0_in    = idx_ff - AW'(1);
               r1_in    = idx_ff;
               ylo_in   = prev_ff;
               yhi_in   = y_rdata;
               ypair_in = 1'b1;
               state_in = S_C0;
            end else begin
               prev_in  = y_rdata;
               idx_in   = idx_ff + AW'(1);
               state_in = S_YS;
            end
         end
         S_C0: state_in = S_C0W;
         S_C0W: begin
            v1_in    = cell_val;
            state_in = ypair_ff ? S_C1 : S_CD;
         end
         S_C1: state_in = S_C1W;
         S_C1W: begin
            lerp_req.start = 1'b1;
            lerp_req.v1    = v1_ff;
            lerp_req.v2    = cell_val;
            lerp_req.dx    = dy_full[BYTE_W-1:0];
            lerp_req.span  = yhi_ff - ylo_ff;
            state_in       = S_CL;
         end
         S_CL: begin
            if (lerp_done) begin
               v1_in    = lerp_result;
               state_in = S_CD;
            end
         end
         S_CD: begin
            if (!col_sel_ff) begin
               zp_in = v1_ff;
               if (p_ff == q_ff) begin
                  z_in     = v1_ff;
                  state_in = S_OUT;
               end else begin
                  col_sel_in = 1'b1;
                  state_in   = S_C0;
               end
            end else if (xhi_ff <= xlo_ff) begin
               z_in     = v1_ff;
               state_in = S_OUT;
            end else begin
               lerp_req.start = 1'b1;
               lerp_req.v1    = zp_ff;
               lerp_req.v2    = v1_ff;
               lerp_req.dx    = dx_full[BYTE_W-1:0];
               lerp_req.span  = xhi_ff - xlo_ff;
               state_in       = S_FL;
            end
         end
         S_FL: begin
            if (lerp_done) begin
               z_in     = lerp_result;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = double_ff ? (z_ext <<< 1) : z_ext;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      xlo_ff      <= xlo_in;
      xhi_ff      <= xhi_in;
      ylo_ff      <= ylo_in;
      yhi_ff      <= yhi_in;
      prev_ff     <= prev_in;
      ypair_ff    <= ypair_in;
      col_sel_ff  <= col_sel_in;
      v1_ff       <= v1_in;
      zp_ff       <= zp_in;
      z_ff        <= z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready        = state_ff == S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = rsp_data_ff;

   `BBML_ASSERT_NEXT(a_rsp_load, clock, reset, state_ff == S_OUT && (!rsp_valid_ff || rsp_ready), rsp_valid_ff)
   `BBML_ASSERT_IMPLY(a_bracket, clock, reset, state_ff == S_C0 || state_ff == S_CD, q_ff == p_ff || q_ff == p_ff + AW'(1))
   `BBML_ASSERT_IMPLY(a_lerp_owner, clock, reset, lerp_busy, state_ff == S_CL || state_ff == S_FL)

endmodule

// File: sv/bbml_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/bbml_lerp.sv
// Shared interpolation unit: multiply, bit-serial signed divide, add.
module bbml_lerp import bbml_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  lerp_req_type             req,
   output logic                     busy,
   output logic                     done,
   output logic signed [CELL_W-1:0] result
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_MUL  = 2'd1;
   localparam logic [1:0] L_DIV  = 2'd2;
   localparam logic [1:0] L_ADD  = 2'd3;
   localparam int CNT_W = $clog2(PROD_MAG_W);

   logic [1:0]               st_ff, st_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic signed [CELL_W-1:0] v1_ff, v1_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [BYTE_W-1:0]        dx_ff, dx_in;
   logic [BYTE_W-1:0]        span_ff, span_in;
   logic                     neg_ff, neg_in;
   logic [PROD_MAG_W-1:0]    dvd_ff, dvd_in;
   logic [BYTE_W-1:0]        rem_ff, rem_in;
   logic signed [CELL_W-1:0] res_ff, res_in;

   logic signed [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]         prod_mag;
   logic [BYTE_W:0]           trial;
   logic                      fits;
   logic signed [PROD_W-1:0]  quo_s;
   logic signed [PROD_W-1:0]  sum;

   always_comb begin
      prod     = PROD_W'(diff_ff) * $signed({1'b0, dx_ff});
      prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
      trial    = {rem_ff, dvd_ff[PROD_MAG_W-1]};
      fits     = trial >= {1'b0, span_ff};
      quo_s    = neg_ff ? -$signed({2'b00, dvd_ff}) : $signed({2'b00, dvd_ff});
      sum      = PROD_W'(v1_ff) + quo_s;
   end

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      v1_in   = v1_ff;
      diff_in = diff_ff;
      dx_in   = dx_ff;
      span_in = span_ff;
      neg_in  = neg_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      unique case (st_ff)
         L_IDLE: begin
            if (req.start) begin
               v1_in   = req.v1;
               diff_in = DIFF_W'(req.v2) - DIFF_W'(req.v1);
               dx_in   = req.dx;
               span_in = req.span;
               st_in   = L_MUL;
            end
         end
         L_MUL: begin
            neg_in = prod[PROD_W-1];
            dvd_in = prod_mag[PROD_MAG_W-1:0];
            rem_in = '0;
            cnt_in = '0;
            st_in  = L_DIV;
         end
         L_DIV: begin
            rem_in = fits ? BYTE_W'(trial - {1'b0, span_ff}) : trial[BYTE_W-1:0];
            dvd_in = {dvd_ff[PROD_MAG_W-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PROD_MAG_W - 1)) begin
               st_in = L_ADD;
            end
         end
         L_ADD: begin
            res_in  = sum[CELL_W-1:0];
            done_in = 1'b1;
            st_in   = L_IDLE;
         end
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      v1_ff   <= v1_in;
      diff_ff <= diff_in;
      dx_ff   <= dx_in;
      span_ff <= span_in;
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign busy   = st_ff != L_IDLE;
   assign done   = done_ff;
   assign result = res_ff;

endmodule

// File: tb/sv/breakpoint_bilinear_map_lookup_test.sv
// Self-checking testbench for the breakpoint bilinear map lookup: directed and random traffic.
module breakpoint_bilinear_map_lookup_test import bbml_pkg::*;;

   localparam int POINTS = 32;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_ready;
   logic [1:0]                req_command = CMD_LOOKUP;
   logic [INDEX_W-1:0]        req_row_index = 0;
   logic [INDEX_W-1:0]        req_column_index = 0;
   logic [BYTE_W-1:0]         req_write_value = 0;
   logic signed [COORD_W-1:0] req_x_value = 0;
   logic signed [COORD_W-1:0] req_y_value = 0;
   logic                      rsp_valid;
   logic                      rsp_ready = 0;
   logic signed [COORD_W-1:0] rsp_interpolated;
   logic                      csr_we = 0;
   logic [1:0]                csr_index = CSR_LAST_COL;
   logic [INDEX_W-1:0]        csr_wdata = 0;

   breakpoint_bilinear_map_lookup uut (.*);

   // shadow of the block
   logic [7:0] x_axis [POINTS];
   logic [7:0] y_axis [POINTS];
   logic [7:0] map    [POINTS][POINTS];
   int unsigned last_col = 15, last_row = 16;
   bit          cells_signed = 0, doubling = 0;

   logic signed [15:0] expected_values [$];
   int errors = 0, lookups = 0, writes = 0, results = 0;
   int send_idle = 0, rsp_stall = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   function automatic int cell_at(int r, int c);
      int v;
      v = map[r][c];
      if (cells_signed && v[7]) v -= 256;
      return v;
   endfunction

   function automatic int blend(int v1, int v2, int dx, int span);
      return v1 + ((v2 - v1) * dx) / span;
   endfunction

   function automatic int column_value(int col, int y);
      int lo, hi;
      if (y < int'(y_axis[0])) return cell_at(0, col);
      if (y >= int'(y_axis[last_row])) return cell_at(last_row, col);
      for (int b = 1; b <= last_row; b++) begin
         if (y < int'(y_axis[b])) begin
            lo = y_axis[b-1];
            hi = y_axis[b];
            return blend(cell_at(b-1, col), cell_at(b, col), y - lo, hi - lo);
         end
      end
      return cell_at(last_row, col);
   endfunction

   function automatic logic [15:0] predict_lookup(int x, int y);
      int p, q, zp, zq, lo, hi, z;
      p = last_col;
      q = last_col;
      if (x <= int'(x_axis[0])) begin
         p = 0;
         q = 0;
      end else if (x < int'(x_axis[last_col])) begin
         for (int i = 1; i <= last_col; i++) begin
            if (x <= int'(x_axis[i])) begin
               p = i - 1;
               q = i;
               break;
            end
         end
      end
      zp = column_value(p, y);
      if (p == q) z = zp;
      else begin
         zq = column_value(q, y);
         lo = x_axis[p];
         hi = x_axis[q];
         z = (hi <= lo) ? zq : blend(zp, zq, x - lo, hi - lo);
      end
      if (doubling) z = z * 2;
      return z[15:0];
   endfunction

   // response side: check and random stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results++;
         if (expected_values.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0d", $time,
                     rsp_interpolated);
         end else begin
            if (rsp_interpolated !== expected_values[0]) begin
               errors++;
               $display("%0t: interpolated mismatch, expected %0d, actual %0d", $time,
                        expected_values[0], rsp_interpolated);
            end
            void'(expected_values.pop_front());
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall);
   end

   task automatic send_item(logic [1:0] cmd, int row, int col, int val, int x, int y);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid        <= 1;
      req_command      <= cmd;
      req_row_index    <= INDEX_W'(row);
      req_column_index <= INDEX_W'(col);
      req_write_value  <= BYTE_W'(val);
      req_x_value      <= COORD_W'(x);
      req_y_value      <= COORD_W'(y);
      do @(posedge clock); while (!req_ready);
      case (cmd)
         CMD_WRITE_X: x_axis[INDEX_W'(col)] = BYTE_W'(val);
         CMD_WRITE_Y: y_axis[INDEX_W'(row)] = BYTE_W'(val);
         CMD_WRITE_M: map[INDEX_W'(row)][INDEX_W'(col)] = BYTE_W'(val);
         default: expected_values.push_back(predict_lookup(int'(signed'(16'(x))),
                                                           int'(signed'(16'(y)))));
      endcase
      if (cmd == CMD_LOOKUP) lookups++;
      else writes++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic configure(int col, int row, bit sgn, bit dbl);
      logic [1:0] idx [4];
      int vals [4];
      idx  = '{CSR_LAST_COL, CSR_LAST_ROW, CSR_SIGNED, CSR_DOUBLE};
      vals = '{col, row, sgn, dbl};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1;
         csr_index <= idx[i];
         csr_wdata <= INDEX_W'(vals[i]);
         @(posedge clock);
      end
      csr_we <= 0;
      last_col = col;
      last_row = row;
      cells_signed = sgn;
      doubling = dbl;
   endtask

   task automatic load_axes();
      int xv, yv;
      xv = $urandom_range(10);
      yv = $urandom_range(10);
      for (int i = 0; i < POINTS; i++) begin
         send_item(CMD_WRITE_X, $urandom_range(31), i, xv, $urandom, $urandom);
         send_item(CMD_WRITE_Y, i, $urandom_range(31), yv, $urandom, $urandom);
         xv += $urandom_range(1, 7);
         yv += $urandom_range(1, 7);
      end
   endtask

   task automatic test_table_load();
      load_axes();
      for (int r = 0; r < POINTS; r++)
         for (int c = 0; c < POINTS; c++)
            send_item(CMD_WRITE_M, r, c, $urandom_range(255), $urandom, $urandom);
   endtask

   task automatic test_directed();
      send_item(CMD_LOOKUP, 0, 0, 0, -32768, -32768);
      send_item(CMD_LOOKUP, 31, 31, 255, 32767, 32767);
      send_item(CMD_LOOKUP, 0, 0, 0, x_axis[0], y_axis[0]);
      send_item(CMD_LOOKUP, 0, 0, 0, x_axis[last_col], y_axis[last_row]);
      send_item(CMD_LOOKUP, 0, 0, 0, x_axis[3], y_axis[5]);
      send_item(CMD_LOOKUP, 0, 0, 0, x_axis[3] - 1, y_axis[5] - 1);
      drain();
      configure(31, 31, 1, 1);
      send_item(CMD_WRITE_M, 0, 0, 8'h80, 0, 0);
      send_item(CMD_WRITE_M, 31, 31, 8'h7f, 0, 0);
      send_item(CMD_LOOKUP, 0, 0, 0, -1, -1);
      send_item(CMD_LOOKUP, 0, 0, 0, 1000, 1000);
      send_item(CMD_LOOKUP, 0, 0, 0, x_axis[30] + 1, y_axis[30] + 1);
      drain();
      configure(0, 0, 0, 1);
      send_item(CMD_LOOKUP, 0, 0, 0, 100, -100);
      send_item(CMD_LOOKUP, 0, 0, 0, -100, 100);
      drain();
      // axes out of order
      configure(4, 4, 1, 0);
      send_item(CMD_WRITE_X, 0, 2, 200, 0, 0);
      send_item(CMD_WRITE_Y, 1, 0, 250, 0, 0);
      send_item(CMD_LOOKUP, 0, 0, 0, 60, 30);
      send_item(CMD_LOOKUP, 0, 0, 0, 210, 240);
      drain();
   endtask

   task automatic test_random();
      int x, y, k;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase % 4)
            0: begin send_idle = 0;  rsp_stall = 0;  end
            1: begin send_idle = 46; rsp_stall = 0;  end
            2: begin send_idle = 0;  rsp_stall = 46; end
            default: begin send_idle = 13; rsp_stall = 13; end
         endcase
         if (phase == 0) configure(15, 16, 0, 0);
         else if (phase == 3) configure(31, 31, 1, 1);
         else configure($urandom_range(31), $urandom_range(31), $urandom_range(1),
                        $urandom_range(1));
         if (phase == 0) load_axes();
         for (int n = 0; n < 84; n++) begin
            k = $urandom_range(99);
            if ($urandom_range(3) == 0) begin
               x = $signed(16'($urandom));
               y = $signed(16'($urandom));
            end else begin
               x = $urandom_range(300) - 20;
               y = $urandom_range(300) - 20;
            end
            if (k < 82) send_item(CMD_LOOKUP, $urandom, $urandom, $urandom, x, y);
            else if (k < 96)
               send_item(CMD_WRITE_M, $urandom_range(31), $urandom_range(31),
                         $urandom_range(255), x, y);
            else if (k < 98)
               send_item(CMD_WRITE_X, $urandom_range(31), $urandom_range(31),
                         $urandom_range(255), x, y);
            else
               send_item(CMD_WRITE_Y, $urandom_range(31), $urandom_range(31),
                         $urandom_range(255), x, y);
         end
         drain();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_table_load();
      test_directed();
      test_random();
      $display("Covered %0d lookups and %0d table writes, %0d results checked.",
               lookups, writes, results);
      $display("Config extremes, signed and doubled cells, clamped and unordered axes.");
      if (errors == 0 && expected_values.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
